@@ sv/spf_pkg.sv @@
// spf_pkg: shared constants, types and the control store for the
// smallest-prime-factor factorizer. No dependencies.
`timescale 1ns / 1ps

package spf_pkg;

    // Table geometry and field widths
    localparam int TABLE_SIZE = 1024;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int NUM_W      = 10;
    localparam int CMP_W      = 17;   // wide enough to compare against any table size below 2**17
    localparam int TDATA_W    = 16;
    localparam int UPC_W      = 4;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // One table entry: smallest prime factor and the cofactor n / spf[n]
    typedef struct packed {
        logic [ADDR_W-1:0] quot;
        logic [ADDR_W-1:0] spf;
    } entry_t;

    // Datapath actions
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_CLR,     // write zero entry, step address
        ACT_PINIT,   // first sieve candidate
        ACT_PRIME,   // mark candidate if prime, set up multiples
        ACT_MARK,    // mark one multiple if still empty
        ACT_PNEXT,   // next sieve candidate
        ACT_LOAD,    // take a query beat
        ACT_EMIT,    // send one factor, follow the cofactor
        ACT_SPEC     // send the no-factor or invalid beat
    } act_t;

    // Jump conditions; jump to target when true, else fall through
    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_CLR_MORE,    // clearing pass not at last entry
        CND_SKIP_MARK,   // candidate composite or square beyond table
        CND_MULT_MORE,   // next multiple still inside table
        CND_P_MORE,      // more candidates to sieve
        CND_NUM_SPEC,    // query is 0, 1 or out of range
        CND_FACT_LAST    // cofactor reached one
    } cond_t;

    // Handshake a step waits on before it executes
    typedef enum logic [1:0] {
        WT_NONE,
        WT_IN,
        WT_OUT
    } wait_t;

    typedef struct packed {
        act_t             act;
        cond_t            cnd;
        wait_t            wt;
        logic [UPC_W-1:0] target;
    } ctrl_word_t;

    // Step addresses
    localparam logic [UPC_W-1:0] STEP_CLEAR = 4'd0;
    localparam logic [UPC_W-1:0] STEP_PINIT = 4'd1;
    localparam logic [UPC_W-1:0] STEP_PWAIT = 4'd2;
    localparam logic [UPC_W-1:0] STEP_PTEST = 4'd3;
    localparam logic [UPC_W-1:0] STEP_MWAIT = 4'd4;
    localparam logic [UPC_W-1:0] STEP_MTEST = 4'd5;
    localparam logic [UPC_W-1:0] STEP_PNEXT = 4'd6;
    localparam logic [UPC_W-1:0] STEP_IDLE  = 4'd7;
    localparam logic [UPC_W-1:0] STEP_FWAIT = 4'd8;
    localparam logic [UPC_W-1:0] STEP_FEMIT = 4'd9;
    localparam logic [UPC_W-1:0] STEP_FNEXT = 4'd10;
    localparam logic [UPC_W-1:0] STEP_SPEC  = 4'd11;

    // Control store
    function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
        ctrl_word_t cw;
        cw = '{act: ACT_NOP, cnd: CND_ALWAYS, wt: WT_NONE, target: STEP_CLEAR};
        unique case (upc)
            STEP_CLEAR: cw = '{act: ACT_CLR,   cnd: CND_CLR_MORE,  wt: WT_NONE, target: STEP_CLEAR};
            STEP_PINIT: cw = '{act: ACT_PINIT, cnd: CND_NEVER,     wt: WT_NONE, target: STEP_CLEAR};
            STEP_PWAIT: cw = '{act: ACT_NOP,   cnd: CND_NEVER,     wt: WT_NONE, target: STEP_CLEAR};
            STEP_PTEST: cw = '{act: ACT_PRIME, cnd: CND_SKIP_MARK, wt: WT_NONE, target: STEP_PNEXT};
            STEP_MWAIT: cw = '{act: ACT_NOP,   cnd: CND_NEVER,     wt: WT_NONE, target: STEP_CLEAR};
            STEP_MTEST: cw = '{act: ACT_MARK,  cnd: CND_MULT_MORE, wt: WT_NONE, target: STEP_MWAIT};
            STEP_PNEXT: cw = '{act: ACT_PNEXT, cnd: CND_P_MORE,    wt: WT_NONE, target: STEP_PWAIT};
            STEP_IDLE:  cw = '{act: ACT_LOAD,  cnd: CND_NUM_SPEC,  wt: WT_IN,   target: STEP_SPEC};
            STEP_FWAIT: cw = '{act: ACT_NOP,   cnd: CND_NEVER,     wt: WT_NONE, target: STEP_CLEAR};
            STEP_FEMIT: cw = '{act: ACT_EMIT,  cnd: CND_FACT_LAST, wt: WT_OUT,  target: STEP_IDLE};
            STEP_FNEXT: cw = '{act: ACT_NOP,   cnd: CND_ALWAYS,    wt: WT_NONE, target: STEP_FEMIT};
            STEP_SPEC:  cw = '{act: ACT_SPEC,  cnd: CND_ALWAYS,    wt: WT_OUT,  target: STEP_IDLE};
            default:    cw = '{act: ACT_NOP,   cnd: CND_ALWAYS,    wt: WT_NONE, target: STEP_CLEAR};
        endcase
        return cw;
    endfunction

endpackage

@@ sv/spf_prime_factorizer_top.sv @@
// spf_prime_factorizer_top: sieve-built smallest-prime-factor table and
// a microcoded sequencer that factors each query. Depends on spf_pkg.
`timescale 1ns / 1ps

//  Channel  | Dir | Beat carries
//  ---------+-----+-----------------------------------------------------
//  s_axis   | in  | tdata[9:0] number
//  m_axis   | out | tdata[9:0] factor, tlast last, tuser[1:0] status
//
// After reset a clearing pass writes zero to all 1024 table entries,
// then the sieve runs over each candidate and the multiples it visits;
// s_axis_tready stays low until it is done. A query is loaded, then each
// factor is read through the table's registered read port and sent in
// turn; 0, 1 and out-of-range queries get a single status beat instead.
// A held result on m_axis stalls the sequencer at its next emit step.

module spf_prime_factorizer_top
    import spf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [9:0] number, rest zero
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [9:0] factor, rest zero
    output logic               m_axis_tlast,
    output logic [1:0]         m_axis_tuser    // [1:0] status
);

    // Sequencer and datapath registers
    logic [UPC_W-1:0]  upc_reg,    upc_next;
    logic [ADDR_W-1:0] addr_reg,   addr_next;
    logic [ADDR_W-1:0] p_reg,      p_next;
    logic [ADDR_W-1:0] k_reg,      k_next;
    logic [1:0]        spec_reg,   spec_next;
    logic              ovalid_reg, ovalid_next;
    logic [NUM_W-1:0]  ofact_reg,  ofact_next;
    logic              olast_reg,  olast_next;
    logic [1:0]        ostat_reg,  ostat_next;

    // Table
    entry_t mem [TABLE_SIZE];
    entry_t rdata_reg;
    logic   wr_en;
    entry_t wr_data;

    ctrl_word_t          cw;
    logic                out_free;
    logic                go;
    logic                cond_true;
    logic [NUM_W-1:0]    in_num;
    logic                num_spec;
    logic                empty;
    logic [2*ADDR_W-1:0] p_sq;
    logic                p_small;
    logic [ADDR_W:0]     mult_sum;

    assign cw       = ucode_rom(upc_reg);
    assign in_num   = s_axis_tdata[NUM_W-1:0];
    assign out_free = !ovalid_reg || m_axis_tready;
    assign empty    = (rdata_reg.spf == '0);
    assign p_sq     = {{ADDR_W{1'b0}}, p_reg} * {{ADDR_W{1'b0}}, p_reg};
    assign p_small  = (p_sq < (2*ADDR_W)'(TABLE_SIZE));
    assign mult_sum = {1'b0, addr_reg} + {1'b0, p_reg};
    assign num_spec = (in_num < NUM_W'(2))
                   || ({{(CMP_W-NUM_W){1'b0}}, in_num} >= CMP_W'(TABLE_SIZE));

    // Step stalls until its handshake can complete
    always_comb
    begin
        unique case (cw.wt)
            WT_IN:   go = s_axis_tvalid;
            WT_OUT:  go = out_free;
            default: go = 1'b1;
        endcase
    end

    // Jump condition decode
    always_comb
    begin
        unique case (cw.cnd)
            CND_ALWAYS:    cond_true = 1'b1;
            CND_CLR_MORE:  cond_true = (addr_reg != ADDR_W'(TABLE_SIZE - 1));
            CND_SKIP_MARK: cond_true = !(empty && p_small);
            CND_MULT_MORE: cond_true = (mult_sum < (ADDR_W+1)'(TABLE_SIZE));
            CND_P_MORE:    cond_true = (p_reg != ADDR_W'(TABLE_SIZE - 1));
            CND_NUM_SPEC:  cond_true = num_spec;
            CND_FACT_LAST: cond_true = (rdata_reg.quot <= ADDR_W'(1));
            default:       cond_true = 1'b0;
        endcase
    end

    // Datapath actions and next step
    always_comb
    begin
        upc_next    = upc_reg;
        addr_next   = addr_reg;
        p_next      = p_reg;
        k_next      = k_reg;
        spec_next   = spec_reg;
        ofact_next  = ofact_reg;
        olast_next  = olast_reg;
        ostat_next  = ostat_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        wr_en       = 1'b0;
        wr_data     = '0;

        if (go)
        begin
            upc_next = cond_true ? cw.target : upc_reg + UPC_W'(1);
            unique case (cw.act)
                ACT_CLR:
                begin
                    wr_en     = 1'b1;
                    addr_next = addr_reg + ADDR_W'(1);
                end
                ACT_PINIT:
                begin
                    p_next    = ADDR_W'(2);
                    addr_next = ADDR_W'(2);
                end
                ACT_PRIME:
                begin
                    // untouched candidate is prime: its own factor, cofactor one
                    wr_en     = empty;
                    wr_data   = '{quot: ADDR_W'(1), spf: p_reg};
                    addr_next = p_sq[ADDR_W-1:0];
                    k_next    = p_reg;
                end
                ACT_MARK:
                begin
                    wr_en     = empty;
                    wr_data   = '{quot: k_reg, spf: p_reg};
                    addr_next = mult_sum[ADDR_W-1:0];
                    k_next    = k_reg + ADDR_W'(1);
                end
                ACT_PNEXT:
                begin
                    p_next    = p_reg + ADDR_W'(1);
                    addr_next = p_reg + ADDR_W'(1);
                end
                ACT_LOAD:
                begin
                    addr_next = in_num[ADDR_W-1:0];
                    spec_next = (in_num == NUM_W'(1)) ? ST_NONE : ST_INVALID;
                end
                ACT_EMIT:
                begin
                    ovalid_next = 1'b1;
                    ofact_next  = NUM_W'(rdata_reg.spf);
                    olast_next  = (rdata_reg.quot <= ADDR_W'(1));
                    ostat_next  = ST_OK;
                    addr_next   = rdata_reg.quot;
                end
                ACT_SPEC:
                begin
                    ovalid_next = 1'b1;
                    ofact_next  = '0;
                    olast_next  = 1'b1;
                    ostat_next  = spec_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg    <= STEP_CLEAR;
            addr_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            upc_reg    <= upc_next;
            addr_reg   <= addr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        k_reg     <= k_next;
        spec_reg  <= spec_next;
        ofact_reg <= ofact_next;
        olast_reg <= olast_next;
        ostat_reg <= ostat_next;
    end

    // Table memory: one write port, registered read at the current address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
        rdata_reg <= mem[addr_reg];
    end

    assign s_axis_tready = (cw.wt == WT_IN);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(TDATA_W-NUM_W){1'b0}}, ofact_reg};
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tuser  = ostat_reg;

endmodule

@@ sv/spf_checker.sv @@
// spf_checker: port-level assertions for spf_prime_factorizer_top, and
// the bind that attaches them. Depends on spf_pkg.
`timescale 1ns / 1ps

module spf_checker
    import spf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [TDATA_W-1:0] s_axis_tdata,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic               m_axis_tlast,
    input logic [1:0]         m_axis_tuser
);

    // Held output beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // One query at a time: the sequencer leaves idle after a load
    a_one_query: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("query taken while previous one in progress");

    // Non-ok beats are single and carry no factor
    a_spec_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK)
            |-> m_axis_tlast && (m_axis_tdata == '0)
                && ((m_axis_tuser == ST_NONE) || (m_axis_tuser == ST_INVALID)))
        else $error("bad status beat");

    // Factors are at least two
    a_factor_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_OK) |-> (m_axis_tdata[NUM_W-1:0] >= NUM_W'(2)))
        else $error("factor below two");

    // s_axis_tdata carries only the query number; nothing to check on it here
    logic unused_in;
    assign unused_in = ^s_axis_tdata;

endmodule

bind spf_prime_factorizer_top spf_checker u_spf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
